### hdl/kstc_pkg.sv
// Package for the keyed slot claim table.
// Holds the operation codes, the sequencer states and the command word sent to the cells.
// Depends on nothing.
`default_nettype none

package kstc_pkg;

    typedef enum logic [1:0] {
        FUNC_CLAIM   = 2'd0,
        FUNC_RELEASE = 2'd1,
        FUNC_QUERY   = 2'd2,
        FUNC_REMOVE  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        logic match;
        logic set_bit;
        logic clear_bit;
        logic alloc;
        logic remove;
    } cell_cmd_t;

endpackage

`default_nettype wire

### hdl/kstc_cell.sv
// One table entry of the keyed slot claim table, with its key, slot mask and valid bit.
// Passes hit, free and slot-set flags along the chain to the next cell.
// Depends on kstc_pkg.
`default_nettype none

module kstc_cell #(
    parameter int SLOTS = 8
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire kstc_pkg::cell_cmd_t      cmd,
    input  wire logic [15:0]              req_owner,
    input  wire logic [15:0]              req_comp,
    input  wire logic [SLOTS-1:0]         req_bit,
    input  wire logic                     hit_in,
    input  wire logic                     free_in,
    input  wire logic                     bitset_in,
    output logic                          hit_out,
    output logic                          free_out,
    output logic                          bitset_out
);
    import kstc_pkg::*;

    logic             valid_reg;
    logic [15:0]      owner_reg;
    logic [15:0]      comp_reg;
    logic [SLOTS-1:0] mask_reg;
    logic             sel_hit_reg;
    logic             sel_free_reg;

    logic             hit;
    logic             sel_hit;
    logic             sel_free;
    logic [SLOTS-1:0] cleared_mask;

    always_comb
    begin
        hit          = valid_reg && (owner_reg == req_owner) && (comp_reg == req_comp);
        sel_hit      = hit && !hit_in;
        sel_free     = !valid_reg && !free_in;
        hit_out      = hit_in | hit;
        free_out     = free_in | !valid_reg;
        bitset_out   = bitset_in | (sel_hit && (|(mask_reg & req_bit)));
        cleared_mask = mask_reg & ~req_bit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            sel_hit_reg  <= 1'b0;
            sel_free_reg <= 1'b0;
        end
        else
        begin
            if (cmd.match)
            begin
                sel_hit_reg  <= sel_hit;
                sel_free_reg <= sel_free;
            end
            if (cmd.alloc && sel_free_reg)
                valid_reg <= 1'b1;
            if (cmd.clear_bit && sel_hit_reg && (cleared_mask == '0))
                valid_reg <= 1'b0;
            if (cmd.remove && valid_reg && (owner_reg == req_owner))
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.alloc && sel_free_reg)
        begin
            owner_reg <= req_owner;
            comp_reg  <= req_comp;
            mask_reg  <= req_bit;
        end
        if (cmd.set_bit && sel_hit_reg)
            mask_reg <= mask_reg | req_bit;
        if (cmd.clear_bit && sel_hit_reg)
            mask_reg <= cleared_mask;
    end

endmodule

`default_nettype wire

### hdl/keyed_slot_claim_table.sv
// Keyed slot claim table: a row of entry cells keyed by owner and component id.
// Each input word is a claim, release, query or owner removal; each gives one result word.
// Depends on kstc_pkg and kstc_cell.
//
// Input channel: in_valid, in_stall, func, owner_id, component_id, slot_index.
// Output channel: out_valid, out_stall, ok, table_full.
// A word is taken when valid is high and stall is low at a rising clock edge.
// One word is processed at a time. After acceptance, one cycle compares the key against
// every cell at once, with the lowest hit and lowest free entry chosen along the cell
// chain; the next cycle updates the chosen cell and loads the output register.
// The result is therefore shown two cycles after acceptance, and a new word may be
// taken in the cycle the result appears, giving one word every three cycles.
// A finished result waits in the output register while out_stall is high; a following
// word is still accepted and holds in its update cycle until the register is taken.
// Reset empties the table and the output register at once; no clearing pass is needed.
`default_nettype none

module keyed_slot_claim_table #(
    parameter int TABLE_ENTRIES   = 16,
    parameter int SLOTS_PER_ENTRY = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  func,
    input  wire logic [15:0] owner_id,
    input  wire logic [15:0] component_id,
    input  wire logic [7:0]  slot_index,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             ok,
    output logic             table_full
);
    import kstc_pkg::*;

    state_t                     state_reg;
    state_t                     state_next;
    func_t                      func_reg;
    logic [15:0]                owner_reg;
    logic [15:0]                comp_reg;
    logic [SLOTS_PER_ENTRY-1:0] bit_reg;
    logic                       req_ok_reg;
    logic                       found_reg;
    logic                       any_free_reg;
    logic                       bitset_reg;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic                       ok_reg;
    logic                       ok_next;
    logic                       full_reg;
    logic                       full_next;

    cell_cmd_t                  cmd;
    logic [SLOTS_PER_ENTRY-1:0] in_bit;
    logic                       accept;
    logic                       out_free;

    logic [TABLE_ENTRIES:0]     hit_chain;
    logic [TABLE_ENTRIES:0]     free_chain;
    logic [TABLE_ENTRIES:0]     bitset_chain;

    assign hit_chain[0]    = 1'b0;
    assign free_chain[0]   = 1'b0;
    assign bitset_chain[0] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < TABLE_ENTRIES; g++)
        begin : g_cell
            kstc_cell #(
                .SLOTS(SLOTS_PER_ENTRY)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .cmd       (cmd),
                .req_owner (owner_reg),
                .req_comp  (comp_reg),
                .req_bit   (bit_reg),
                .hit_in    (hit_chain[g]),
                .free_in   (free_chain[g]),
                .bitset_in (bitset_chain[g]),
                .hit_out   (hit_chain[g+1]),
                .free_out  (free_chain[g+1]),
                .bitset_out(bitset_chain[g+1])
            );
        end
    endgenerate

    always_comb
    begin
        for (int i = 0; i < SLOTS_PER_ENTRY; i++)
            in_bit[i] = (slot_index == 8'(i));
    end

    assign in_stall   = (state_reg != ST_IDLE);
    assign accept     = in_valid && (state_reg == ST_IDLE);
    assign out_free   = !out_valid_reg || !out_stall;
    assign out_valid  = out_valid_reg;
    assign ok         = ok_reg;
    assign table_full = full_reg;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && out_stall;
        ok_next        = ok_reg;
        full_next      = full_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_MATCH;
            end
            ST_MATCH:
            begin
                cmd.match  = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (out_free)
                begin
                    ok_next        = 1'b0;
                    full_next      = 1'b0;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    unique case (func_reg)
                        FUNC_CLAIM:
                        begin
                            if (req_ok_reg && found_reg && !bitset_reg)
                            begin
                                cmd.set_bit = 1'b1;
                                ok_next     = 1'b1;
                            end
                            else if (req_ok_reg && !found_reg && any_free_reg)
                            begin
                                cmd.alloc = 1'b1;
                                ok_next   = 1'b1;
                            end
                            else if (req_ok_reg && !found_reg)
                                full_next = 1'b1;
                        end
                        FUNC_RELEASE:
                        begin
                            if (req_ok_reg && found_reg && bitset_reg)
                                cmd.clear_bit = 1'b1;
                        end
                        FUNC_QUERY:
                        begin
                            ok_next = req_ok_reg && found_reg && bitset_reg;
                        end
                        FUNC_REMOVE:
                        begin
                            cmd.remove = (owner_reg != 16'd0);
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg   <= func_t'(func);
            owner_reg  <= owner_id;
            comp_reg   <= component_id;
            bit_reg    <= in_bit;
            req_ok_reg <= (owner_id != 16'd0) && (component_id != 16'd0)
                          && (slot_index < 8'(SLOTS_PER_ENTRY));
        end
        if (cmd.match)
        begin
            found_reg    <= hit_chain[TABLE_ENTRIES];
            any_free_reg <= free_chain[TABLE_ENTRIES];
            bitset_reg   <= bitset_chain[TABLE_ENTRIES];
        end
        ok_reg   <= ok_next;
        full_reg <= full_next;
    end

endmodule

`default_nettype wire
